// ----- src/tndp_pkg.sv -----
// Shared types, constants and fixed-point helpers for the tanh neuron dot-product unit.
package tndp_pkg;

    // Field widths of the stream items.
    localparam int VALUE_WIDTH     = 16;
    localparam int INDEX_WIDTH     = 6;
    localparam int MAX_INPUTS      = 64;
    localparam int COUNT_WIDTH     = 7;
    localparam int IN_TDATA_WIDTH  = 24;
    localparam int OUT_TDATA_WIDTH = 16;

    // Accumulator and tanh datapath widths.
    localparam int ACC_WIDTH    = 40;
    localparam int PROD_WIDTH   = 2 * VALUE_WIDTH;
    localparam int Q_WIDTH      = 5;
    localparam int G_WIDTH      = 23;
    localparam int GG_WIDTH     = 2 * G_WIDTH;
    localparam int T2_WIDTH     = 14;
    localparam int TG_WIDTH     = T2_WIDTH + G_WIDTH;
    localparam int V_WIDTH      = 32;
    localparam int DEN_WIDTH    = 33;
    localparam int REM_WIDTH    = 48;
    localparam int QUOT_BITS    = 16;
    localparam int SQUARE_STEPS = 8;
    localparam int EXP_STEPS    = 23;

    // Opcodes carried on tuser.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_EXCITE = 1'b1;

    // Constants of the fixed-point tanh.
    localparam logic [COUNT_WIDTH-1:0] COUNT_RESET   = 7'd64;
    localparam logic [V_WIDTH-1:0]     Q31_ONE       = 32'h8000_0000;
    localparam logic [V_WIDTH-1:0]     EXP_M1_Q31    = 32'd790015084;
    localparam logic [ACC_WIDTH-1:0]   SAT_LIMIT     = 40'h03_0000_0000;
    localparam logic [VALUE_WIDTH-1:0] ACT_TOP       = 16'h7FFF;
    localparam logic [7:0]             THIRD_RECIP   = 8'd171;

    // Control that travels with an item down the tanh pipeline.
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic               sat;
        logic [Q_WIDTH-1:0] q;
    } tndp_ctl_t;

    // Q.31 product with round to nearest.
    function automatic logic [V_WIDTH-1:0] mul_q31(input logic [V_WIDTH-1:0] a,
                                                   input logic [V_WIDTH-1:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + 64'h4000_0000;
        return p[62:31];
    endfunction

endpackage

// ----- src/tndp_mac.sv -----
// Weight store, multiplier and saturating accumulator of the neuron.
module tndp_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                accept,
    input  logic                                opcode,
    input  logic [tndp_pkg::INDEX_WIDTH-1:0]    index,
    input  logic signed [tndp_pkg::VALUE_WIDTH-1:0] value,
    input  logic [tndp_pkg::COUNT_WIDTH-1:0]    input_count,
    output logic                                sum_valid,
    output logic signed [tndp_pkg::ACC_WIDTH-1:0] sum
);
    import tndp_pkg::*;

    logic signed [VALUE_WIDTH-1:0] mem [MAX_INPUTS];
    logic signed [VALUE_WIDTH-1:0] w_rd_reg;
    logic signed [VALUE_WIDTH-1:0] x_reg;
    logic                          v1_reg, last1_reg;
    logic signed [PROD_WIDTH-1:0]  prod_reg;
    logic                          v2_reg, last2_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic signed [ACC_WIDTH-1:0]   sum_reg;
    logic                          sum_valid_reg;
    logic                          in_range, is_last;
    logic signed [ACC_WIDTH:0]     wide_sum;

    // Position checks against the configured input count.
    assign in_range = ({1'b0, index} < input_count);
    assign is_last  = (COUNT_WIDTH'({1'b0, index} + 7'd1) == input_count);

    // Weight memory: written by load transactions, read for every accepted transaction.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (opcode == OP_LOAD) begin
                mem[index] <= value;
            end
            w_rd_reg <= mem[index];
            x_reg    <= value;
        end
    end

    // Product register.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= x_reg * w_rd_reg;
        end
    end

    // Sum of accumulator and product, saturated to the accumulator range.
    always_comb begin
        wide_sum = {acc_reg[ACC_WIDTH-1], acc_reg}
                 + {{(ACC_WIDTH + 1 - PROD_WIDTH){prod_reg[PROD_WIDTH-1]}}, prod_reg};
        if (wide_sum[ACC_WIDTH] != wide_sum[ACC_WIDTH-1]) begin
            acc_next = wide_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                           : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            acc_next = wide_sum[ACC_WIDTH-1:0];
        end
    end

    // Stage valids and the accumulator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            last1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            last2_reg     <= 1'b0;
            acc_reg       <= '0;
            sum_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= accept && (opcode == OP_EXCITE) && in_range;
            last1_reg     <= is_last;
            v2_reg        <= v1_reg;
            last2_reg     <= last1_reg;
            sum_valid_reg <= v2_reg && last2_reg;
            if (v2_reg) begin
                acc_reg <= last2_reg ? '0 : acc_next;
            end
        end
    end

    // Finished sum handed to the tanh pipeline.
    always_ff @(posedge aclk) begin
        if (en && v2_reg && last2_reg) begin
            sum_reg <= acc_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

// ----- src/tndp_exp.sv -----
// Pipelined exp(-2|x|) in Q.31: polynomial seed, eight squarings, integer-part steps.
module tndp_exp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  sum_valid,
    input  logic signed [tndp_pkg::ACC_WIDTH-1:0] sum,
    output tndp_pkg::tndp_ctl_t                   ctl_out,
    output logic [tndp_pkg::V_WIDTH-1:0]          e_out
);
    import tndp_pkg::*;

    localparam int TOTAL = SQUARE_STEPS + EXP_STEPS;

    logic [ACC_WIDTH-1:0]  mag;
    logic [ACC_WIDTH:0]    mag_wide;
    tndp_ctl_t             ctl0_reg, ctl1_reg, ctl2_reg;
    logic [G_WIDTH-1:0]    g0_reg, g1_reg, g2_reg;
    logic [GG_WIDTH-1:0]   gg_reg;
    logic [T2_WIDTH-1:0]   t2_reg;
    logic [TG_WIDTH-1:0]   tg_reg;
    logic [5:0]            x3;
    logic [13:0]           x3_prod;
    logic [4:0]            t3;
    logic [V_WIDTH-1:0]    seed;
    tndp_ctl_t             ctl_pipe [TOTAL+1];
    logic [V_WIDTH-1:0]    v_pipe [TOTAL+1];

    // Magnitude of the sum; the most negative sum still fits as unsigned.
    assign mag_wide = sum[ACC_WIDTH-1] ? (ACC_WIDTH+1)'(-{sum[ACC_WIDTH-1], sum})
                                       : {1'b0, sum};
    assign mag      = mag_wide[ACC_WIDTH-1:0];

    // Split 2|x| into integer part and the fraction step g.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg.valid <= 1'b0;
        end else if (en) begin
            ctl0_reg.valid <= sum_valid;
            ctl0_reg.neg   <= sum[ACC_WIDTH-1];
            ctl0_reg.sat   <= (mag >= SAT_LIMIT);
            ctl0_reg.q     <= mag[33:29];
            g0_reg         <= mag[28:6];
        end
    end

    // g squared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg.valid <= 1'b0;
        end else if (en) begin
            gg_reg   <= 46'(g0_reg) * 46'(g0_reg);
            g1_reg   <= g0_reg;
            ctl1_reg <= ctl0_reg;
        end
    end

    // Second-order term and the cube product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg.valid <= 1'b0;
        end else if (en) begin
            t2_reg   <= gg_reg[45:32];
            tg_reg   <= TG_WIDTH'(gg_reg[45:32]) * TG_WIDTH'(g1_reg);
            g2_reg   <= g1_reg;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Third-order term divided by three through a reciprocal, then the seed.
    assign x3      = tg_reg[36:31];
    assign x3_prod = 14'(x3) * 14'(THIRD_RECIP);
    assign t3      = x3_prod[13:9];
    assign seed    = Q31_ONE - V_WIDTH'(g2_reg) + V_WIDTH'(t2_reg) - V_WIDTH'(t3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_pipe[0].valid <= 1'b0;
        end else if (en) begin
            v_pipe[0]   <= seed;
            ctl_pipe[0] <= ctl2_reg;
        end
    end

    // Eight squarings, then one multiply by exp(-1) per unit of the integer part.
    for (genvar k = 0; k < TOTAL; k++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_pipe[k+1].valid <= 1'b0;
            end else if (en) begin
                ctl_pipe[k+1] <= ctl_pipe[k];
                if (k < SQUARE_STEPS) begin
                    v_pipe[k+1] <= mul_q31(v_pipe[k], v_pipe[k]);
                end else if (Q_WIDTH'(k - SQUARE_STEPS) < ctl_pipe[k].q) begin
                    v_pipe[k+1] <= mul_q31(v_pipe[k], EXP_M1_Q31);
                end else begin
                    v_pipe[k+1] <= v_pipe[k];
                end
            end
        end
    end

    assign ctl_out = ctl_pipe[TOTAL];
    assign e_out   = v_pipe[TOTAL];

endmodule

// ----- src/tndp_div.sv -----
// Pipelined (1-e)/(1+e) divider with rounding, saturation and sign restore.
module tndp_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  tndp_pkg::tndp_ctl_t                    ctl_in,
    input  logic [tndp_pkg::V_WIDTH-1:0]           e_in,
    output logic                                   act_valid,
    output logic [tndp_pkg::VALUE_WIDTH-1:0]       activation
);
    import tndp_pkg::*;

    logic [V_WIDTH-1:0]     num;
    logic [DEN_WIDTH-1:0]   den;
    tndp_ctl_t              ctl_pipe [QUOT_BITS+1];
    logic [REM_WIDTH-1:0]   rem_pipe [QUOT_BITS+1];
    logic [DEN_WIDTH-1:0]   den_pipe [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   quo_pipe [QUOT_BITS+1];
    logic [VALUE_WIDTH-1:0] mag;
    logic                   act_valid_reg;
    logic [VALUE_WIDTH-1:0] act_reg;

    // Numerator and denominator; the dividend carries half the divisor for rounding.
    assign num = Q31_ONE - e_in;
    assign den = DEN_WIDTH'(Q31_ONE) + DEN_WIDTH'(e_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_pipe[0].valid <= 1'b0;
        end else if (en) begin
            ctl_pipe[0] <= ctl_in;
            rem_pipe[0] <= (REM_WIDTH'(num) << 15) + REM_WIDTH'(den >> 1);
            den_pipe[0] <= den;
            quo_pipe[0] <= '0;
        end
    end

    // Restoring division, one quotient bit per stage from the top bit down.
    for (genvar j = 0; j < QUOT_BITS; j++) begin : g_bit
        logic [REM_WIDTH-1:0] trial;
        assign trial = REM_WIDTH'(den_pipe[j]) << (QUOT_BITS - 1 - j);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_pipe[j+1].valid <= 1'b0;
            end else if (en) begin
                ctl_pipe[j+1] <= ctl_pipe[j];
                den_pipe[j+1] <= den_pipe[j];
                if (rem_pipe[j] >= trial) begin
                    rem_pipe[j+1] <= rem_pipe[j] - trial;
                    quo_pipe[j+1] <= quo_pipe[j] | (QUOT_BITS'(1) << (QUOT_BITS - 1 - j));
                end else begin
                    rem_pipe[j+1] <= rem_pipe[j];
                    quo_pipe[j+1] <= quo_pipe[j];
                end
            end
        end
    end

    // Clamp to the largest positive code; large sums go straight to full scale.
    always_comb begin
        if (ctl_pipe[QUOT_BITS].sat || (quo_pipe[QUOT_BITS] > ACT_TOP)) begin
            mag = ACT_TOP;
        end else begin
            mag = quo_pipe[QUOT_BITS];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_valid_reg <= 1'b0;
        end else if (en) begin
            act_valid_reg <= ctl_pipe[QUOT_BITS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act_reg <= ctl_pipe[QUOT_BITS].neg ? VALUE_WIDTH'(-mag) : mag;
        end
    end

    assign act_valid  = act_valid_reg;
    assign activation = act_reg;

endmodule

// ----- src/tanh_neuron_dot_product_unit.sv -----
// The activation follows the last excitation transaction through the MAC, exp and divider pipelines.
// Throughput: one transaction per cycle; the multiply-accumulate and every tanh stage are
// fully pipelined, and the whole pipeline holds only while a result waits on m_tready.
// Reset: aresetn (synchronous, active low) clears the accumulator and all stage valids and
// sets input_count to 64; weights stay undefined until loaded.
module tanh_neuron_dot_product_unit (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // Input stream.
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [tndp_pkg::IN_TDATA_WIDTH-1:0]       s_tdata,  // index[5:0], value[21:6], zero pad
    input  logic                                      s_tuser,  // opcode
    // Result stream.
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [tndp_pkg::OUT_TDATA_WIDTH-1:0]      m_tdata,  // activation[15:0]
    // Configuration write channel (input_count).
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [tndp_pkg::COUNT_WIDTH-1:0]          cfg_data
);
    import tndp_pkg::*;

    logic                          en;
    logic                          accept;
    logic [COUNT_WIDTH-1:0]        count_reg;
    logic                          sum_valid;
    logic signed [ACC_WIDTH-1:0]   sum;
    tndp_ctl_t                     exp_ctl;
    logic [V_WIDTH-1:0]            exp_val;
    logic                          act_valid;
    logic [VALUE_WIDTH-1:0]        activation;

    // The pipeline advances unless a result is held at the output.
    assign en       = !act_valid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // Input count register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    tndp_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .accept      (accept),
        .opcode      (s_tuser),
        .index       (s_tdata[INDEX_WIDTH-1:0]),
        .value       (s_tdata[INDEX_WIDTH+VALUE_WIDTH-1:INDEX_WIDTH]),
        .input_count (count_reg),
        .sum_valid   (sum_valid),
        .sum         (sum)
    );

    tndp_exp u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .sum_valid (sum_valid),
        .sum       (sum),
        .ctl_out   (exp_ctl),
        .e_out     (exp_val)
    );

    tndp_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ctl_in     (exp_ctl),
        .e_in       (exp_val),
        .act_valid  (act_valid),
        .activation (activation)
    );

    assign m_tvalid = act_valid;
    assign m_tdata  = activation;

endmodule
